// File: rtl/core/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg: shared types and constants for the text console glyph renderer
// Item layouts, register indexes, character codes, controller/datapath
// command and status bundles, and character classification helpers.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  // Default glyph geometry and store size.
  localparam int GLYPH_HEIGHT_DEF = 16;
  localparam int GLYPH_COUNT_DEF  = 128;

  // Field widths.
  localparam int COL_W      = 8;
  localparam int ROW_W      = 8;
  localparam int PITCH_W    = 14;
  localparam int COLOUR_W   = 32;
  localparam int OFF_W      = 26;
  localparam int FADDR_W    = 11;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // A glyph is eight pixels wide, so a column is three address bits of shift.
  localparam int GLYPH_W_SHIFT = 3;

  // Register reset values.
  localparam logic [COL_W-1:0]    TEXT_COLUMNS_RST = 8'd80;
  localparam logic [ROW_W-1:0]    TEXT_ROWS_RST    = 8'd30;
  localparam logic [PITCH_W-1:0]  LINE_PITCH_RST   = 14'd640;
  localparam logic [COLOUR_W-1:0] FG_COLOUR_RST    = 32'hFFFF_FFFF;
  localparam logic [COLOUR_W-1:0] BG_COLOUR_RST    = 32'h0000_0000;

  // Character codes.
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_RETURN  = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_FIRST   = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_LAST    = 8'h7F;
  localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [COL_W:0]    TAB_STEP     = 9'd4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_COLUMNS = 3'd0,
    CFG_TEXT_ROWS    = 3'd1,
    CFG_LINE_PITCH   = 3'd2,
    CFG_FG_COLOUR    = 3'd3,
    CFG_BG_COLOUR    = 3'd4
  } cfg_reg_t;

  // Input opcodes and result kinds.
  localparam logic OP_PUT_CHAR     = 1'b0;
  localparam logic OP_FONT_WRITE   = 1'b1;
  localparam logic KIND_GLYPH_ROW  = 1'b0;
  localparam logic KIND_SCROLL     = 1'b1;

  // Input item.
  typedef struct packed {
    logic               opcode;
    logic [BYTE_W-1:0]  char_code;
    logic [FADDR_W-1:0] font_address;
    logic [BYTE_W-1:0]  font_byte;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic                kind;
    logic [OFF_W-1:0]    pixel_offset;
    logic [BYTE_W-1:0]   row_bits;
    logic [COLOUR_W-1:0] fore_value;
    logic [COLOUR_W-1:0] back_value;
    logic                last;
  } out_item_t;

  // What an input item asks for.
  typedef enum logic [2:0] {
    CLS_FONT,
    CLS_NEWLINE,
    CLS_RETURN,
    CLS_TAB,
    CLS_GLYPH
  } char_class_t;

  // Cursor movement selector.
  typedef enum logic [1:0] {
    ADV_NEWLINE,
    ADV_RETURN,
    ADV_TAB,
    ADV_GLYPH
  } adv_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BASE,
    ST_ROWS,
    ST_SCROLL
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic font_wr;
    logic ld_glyph;
    logic ld_base;
    logic row_load;
    logic scroll_load;
    logic cursor_commit;
    adv_t adv_sel;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    char_class_t in_class;
    logic        out_free;
    logic        row_last;
    logic        scroll;
  } ctrl_sts_t;

  // Sort an input item into the action it requires.
  function automatic char_class_t classify(input in_item_t item);
    char_class_t cls;
    if (item.opcode == OP_FONT_WRITE) begin
      cls = CLS_FONT;
    end else begin
      case (item.char_code)
        CHAR_NEWLINE: cls = CLS_NEWLINE;
        CHAR_RETURN:  cls = CLS_RETURN;
        CHAR_TAB:     cls = CLS_TAB;
        default:      cls = CLS_GLYPH;
      endcase
    end
    return cls;
  endfunction

  // Bytes outside 0x20 to 0x7F draw as a space.
  function automatic logic [BYTE_W-1:0] glyph_of(input logic [BYTE_W-1:0] ch);
    return (ch inside {[CHAR_FIRST:CHAR_LAST]}) ? ch : CHAR_SPACE;
  endfunction

endpackage

// File: rtl/core/tcgr_ram.sv
// ----------------------------------------------------------------------------
// tcgr_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/tcgr_ctrl.sv
// ----------------------------------------------------------------------------
// tcgr_ctrl: sequencing state machine
// Accepts items when idle, then walks a glyph through its offset setup,
// its row emission and an optional scroll, which a newline or tab may also add.
// ----------------------------------------------------------------------------
module tcgr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                cfg_ready,
  input  tcgr_pkg::ctrl_sts_t sts,
  output tcgr_pkg::ctrl_cmd_t cmd
);

  tcgr_pkg::state_t state_r;
  tcgr_pkg::state_t state_nxt;
  logic             accept;

  assign accept = in_valid && (state_r == tcgr_pkg::ST_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcgr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcgr_pkg::ST_IDLE: begin
        if (accept) begin
          if (sts.in_class == tcgr_pkg::CLS_GLYPH) begin
            state_nxt = tcgr_pkg::ST_BASE;
          end else if ((sts.in_class == tcgr_pkg::CLS_NEWLINE ||
                        sts.in_class == tcgr_pkg::CLS_TAB) && sts.scroll) begin
            state_nxt = tcgr_pkg::ST_SCROLL;
          end
        end
      end
      tcgr_pkg::ST_BASE: begin
        state_nxt = tcgr_pkg::ST_ROWS;
      end
      tcgr_pkg::ST_ROWS: begin
        if (sts.out_free && sts.row_last) begin
          state_nxt = sts.scroll ? tcgr_pkg::ST_SCROLL : tcgr_pkg::ST_IDLE;
        end
      end
      tcgr_pkg::ST_SCROLL: begin
        if (sts.out_free) begin
          state_nxt = tcgr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcgr_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_stall          = (state_r != tcgr_pkg::ST_IDLE);
    cfg_ready         = (state_r == tcgr_pkg::ST_IDLE);
    cmd.font_wr       = 1'b0;
    cmd.ld_glyph      = 1'b0;
    cmd.ld_base       = 1'b0;
    cmd.row_load      = 1'b0;
    cmd.scroll_load   = 1'b0;
    cmd.cursor_commit = 1'b0;
    cmd.adv_sel       = tcgr_pkg::ADV_GLYPH;
    case (state_r)
      tcgr_pkg::ST_IDLE: begin
        case (sts.in_class)
          tcgr_pkg::CLS_NEWLINE: cmd.adv_sel = tcgr_pkg::ADV_NEWLINE;
          tcgr_pkg::CLS_RETURN:  cmd.adv_sel = tcgr_pkg::ADV_RETURN;
          tcgr_pkg::CLS_TAB:     cmd.adv_sel = tcgr_pkg::ADV_TAB;
          default:               cmd.adv_sel = tcgr_pkg::ADV_GLYPH;
        endcase
        cmd.font_wr       = accept && (sts.in_class == tcgr_pkg::CLS_FONT);
        cmd.ld_glyph      = accept && (sts.in_class == tcgr_pkg::CLS_GLYPH);
        cmd.cursor_commit = accept && (sts.in_class == tcgr_pkg::CLS_NEWLINE ||
                                       sts.in_class == tcgr_pkg::CLS_RETURN ||
                                       sts.in_class == tcgr_pkg::CLS_TAB);
      end
      tcgr_pkg::ST_BASE: begin
        cmd.ld_base = 1'b1;
      end
      tcgr_pkg::ST_ROWS: begin
        cmd.row_load      = sts.out_free;
        cmd.cursor_commit = sts.out_free && sts.row_last;
      end
      tcgr_pkg::ST_SCROLL: begin
        cmd.scroll_load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

  // The offset setup state is always followed by row emission.
  a_base_then_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcgr_pkg::ST_BASE) |=> (state_r == tcgr_pkg::ST_ROWS))
    else $error("offset setup not followed by row emission");

  // While rows go out, the cursor moves only with the final row.
  a_commit_on_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcgr_pkg::ST_ROWS && cmd.cursor_commit) |-> (cmd.row_load && sts.row_last))
    else $error("cursor moved before the final glyph row");

endmodule

// File: rtl/core/tcgr_dpath.sv
// ----------------------------------------------------------------------------
// tcgr_dpath: renderer datapath
// Holds the registers, the cursor, the font store, the row address and
// pixel offset accumulators, and the result register.
// ----------------------------------------------------------------------------
module tcgr_dpath #(
  parameter int GLYPH_HEIGHT = tcgr_pkg::GLYPH_HEIGHT_DEF,
  parameter int GLYPH_COUNT  = tcgr_pkg::GLYPH_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tcgr_pkg::ctrl_cmd_t                 cmd,
  output tcgr_pkg::ctrl_sts_t                 sts,
  input  tcgr_pkg::in_item_t                  in_item,
  input  logic                                cfg_we,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                out_stall,
  output logic                                out_valid,
  output tcgr_pkg::out_item_t                 out_item
);

  localparam int DEPTH   = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int AW      = $clog2(DEPTH);
  localparam int RCW     = $clog2(GLYPH_HEIGHT);
  localparam int ROWGH_W = tcgr_pkg::ROW_W + $clog2(GLYPH_HEIGHT);
  localparam int OFF_W   = tcgr_pkg::OFF_W;

  // Configuration registers.
  logic [tcgr_pkg::COL_W-1:0]    text_columns_r, text_columns_nxt;
  logic [tcgr_pkg::ROW_W-1:0]    text_rows_r, text_rows_nxt;
  logic [tcgr_pkg::PITCH_W-1:0]  line_pitch_r, line_pitch_nxt;
  logic [tcgr_pkg::COLOUR_W-1:0] fg_colour_r, fg_colour_nxt;
  logic [tcgr_pkg::COLOUR_W-1:0] bg_colour_r, bg_colour_nxt;

  // Cursor and glyph walk state.
  logic [tcgr_pkg::COL_W-1:0] cursor_col_r, cursor_col_nxt;
  logic [tcgr_pkg::ROW_W-1:0] cursor_row_r, cursor_row_nxt;
  logic [AW-1:0]              rd_addr_r, rd_addr_nxt;
  logic [RCW-1:0]             row_cnt_r, row_cnt_nxt;
  logic [OFF_W-1:0]           off_r, off_nxt;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  tcgr_pkg::out_item_t out_item_r, out_item_nxt;

  // Font store ports.
  logic [31:0]                 fa_wide;
  logic                        ram_wr_en;
  logic [AW-1:0]               ram_wr_addr;
  logic [tcgr_pkg::BYTE_W-1:0] ram_rd_data;
  logic [AW-1:0]               glyph_base;

  // Cursor movement.
  logic [tcgr_pkg::COL_W:0]   col_sum;
  logic [tcgr_pkg::COL_W:0]   col_step;
  logic                       col_wrap;
  logic [tcgr_pkg::COL_W-1:0] adv_col;
  logic [tcgr_pkg::ROW_W:0]   adv_row;
  logic                       adv_scroll;
  logic [tcgr_pkg::ROW_W-1:0] adv_row_final;

  // Offset setup.
  logic [ROWGH_W-1:0] row_gh;
  logic [OFF_W-1:0]   base_off;

  logic row_last;

  // Font store write, dropped when the address lies past the store.
  assign fa_wide     = 32'(in_item.font_address);
  assign ram_wr_en   = cmd.font_wr && (fa_wide < 32'(DEPTH));
  assign ram_wr_addr = fa_wide[AW-1:0];
  assign glyph_base  = AW'(32'(tcgr_pkg::glyph_of(in_item.char_code)) * 32'(GLYPH_HEIGHT));

  tcgr_ram #(
    .WIDTH (tcgr_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_font_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (in_item.font_byte),
    .rd_addr (rd_addr_nxt),
    .rd_data (ram_rd_data)
  );

  assign row_last = (row_cnt_r == RCW'(GLYPH_HEIGHT - 1));

  // Cursor movement for the selected action, with scroll detection.
  always_comb begin
    col_step = (cmd.adv_sel == tcgr_pkg::ADV_TAB) ? tcgr_pkg::TAB_STEP
                                                  : (tcgr_pkg::COL_W + 1)'(1);
    col_sum  = {1'b0, cursor_col_r} + col_step;
    col_wrap = (col_sum >= {1'b0, text_columns_r});
    adv_col  = '0;
    adv_row  = {1'b0, cursor_row_r};
    case (cmd.adv_sel)
      tcgr_pkg::ADV_NEWLINE: begin
        adv_row = {1'b0, cursor_row_r} + (tcgr_pkg::ROW_W + 1)'(1);
      end
      tcgr_pkg::ADV_RETURN: begin
        adv_row = {1'b0, cursor_row_r};
      end
      default: begin
        if (col_wrap) begin
          adv_row = {1'b0, cursor_row_r} + (tcgr_pkg::ROW_W + 1)'(1);
        end else begin
          adv_col = col_sum[tcgr_pkg::COL_W-1:0];
        end
      end
    endcase
    adv_scroll = (cmd.adv_sel != tcgr_pkg::ADV_RETURN) &&
                 (adv_row >= {1'b0, text_rows_r});
    if (adv_scroll) begin
      adv_row_final = (text_rows_r == '0) ? '0 : text_rows_r - tcgr_pkg::ROW_W'(1);
    end else begin
      adv_row_final = adv_row[tcgr_pkg::ROW_W-1:0];
    end
  end

  // Pixel offset of the glyph's top row.
  assign row_gh   = ROWGH_W'(32'(cursor_row_r) * 32'(GLYPH_HEIGHT));
  assign base_off = OFF_W'(row_gh) * OFF_W'(line_pitch_r)
                  + (OFF_W'(cursor_col_r) << tcgr_pkg::GLYPH_W_SHIFT);

  // Configuration writes.
  always_comb begin
    text_columns_nxt = text_columns_r;
    text_rows_nxt    = text_rows_r;
    line_pitch_nxt   = line_pitch_r;
    fg_colour_nxt    = fg_colour_r;
    bg_colour_nxt    = bg_colour_r;
    if (cfg_we) begin
      case (cfg_index)
        tcgr_pkg::CFG_TEXT_COLUMNS: text_columns_nxt = tcgr_pkg::COL_W'(cfg_data);
        tcgr_pkg::CFG_TEXT_ROWS:    text_rows_nxt    = tcgr_pkg::ROW_W'(cfg_data);
        tcgr_pkg::CFG_LINE_PITCH:   line_pitch_nxt   = tcgr_pkg::PITCH_W'(cfg_data);
        tcgr_pkg::CFG_FG_COLOUR:    fg_colour_nxt    = tcgr_pkg::COLOUR_W'(cfg_data);
        tcgr_pkg::CFG_BG_COLOUR:    bg_colour_nxt    = tcgr_pkg::COLOUR_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Cursor update.
  always_comb begin
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    if (cmd.cursor_commit) begin
      cursor_col_nxt = adv_col;
      cursor_row_nxt = adv_row_final;
    end
  end

  // Font row address, row counter and pixel offset walk.
  always_comb begin
    rd_addr_nxt = rd_addr_r;
    row_cnt_nxt = row_cnt_r;
    off_nxt     = off_r;
    if (cmd.ld_glyph) begin
      rd_addr_nxt = glyph_base;
    end else if (cmd.row_load && !row_last) begin
      rd_addr_nxt = rd_addr_r + AW'(1);
    end
    if (cmd.ld_base) begin
      row_cnt_nxt = '0;
      off_nxt     = base_off;
    end else if (cmd.row_load) begin
      row_cnt_nxt = row_cnt_r + RCW'(1);
      off_nxt     = off_r + OFF_W'(line_pitch_r);
    end
  end

  // Result register: glyph rows and scroll commands.
  always_comb begin
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.row_load) begin
      out_valid_nxt             = 1'b1;
      out_item_nxt.kind         = tcgr_pkg::KIND_GLYPH_ROW;
      out_item_nxt.pixel_offset = off_r;
      out_item_nxt.row_bits     = ram_rd_data;
      out_item_nxt.fore_value   = fg_colour_r;
      out_item_nxt.back_value   = bg_colour_r;
      out_item_nxt.last         = row_last && !adv_scroll;
    end else if (cmd.scroll_load) begin
      out_valid_nxt             = 1'b1;
      out_item_nxt.kind         = tcgr_pkg::KIND_SCROLL;
      out_item_nxt.pixel_offset = '0;
      out_item_nxt.row_bits     = '0;
      out_item_nxt.fore_value   = '0;
      out_item_nxt.back_value   = bg_colour_r;
      out_item_nxt.last         = 1'b1;
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_columns_r <= tcgr_pkg::TEXT_COLUMNS_RST;
      text_rows_r    <= tcgr_pkg::TEXT_ROWS_RST;
      line_pitch_r   <= tcgr_pkg::LINE_PITCH_RST;
      fg_colour_r    <= tcgr_pkg::FG_COLOUR_RST;
      bg_colour_r    <= tcgr_pkg::BG_COLOUR_RST;
      cursor_col_r   <= '0;
      cursor_row_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      text_columns_r <= text_columns_nxt;
      text_rows_r    <= text_rows_nxt;
      line_pitch_r   <= line_pitch_nxt;
      fg_colour_r    <= fg_colour_nxt;
      bg_colour_r    <= bg_colour_nxt;
      cursor_col_r   <= cursor_col_nxt;
      cursor_row_r   <= cursor_row_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    row_cnt_r  <= row_cnt_nxt;
    off_r      <= off_nxt;
    out_item_r <= out_item_nxt;
  end

  // Status back to the controller.
  always_comb begin
    sts.in_class = tcgr_pkg::classify(in_item);
    sts.out_free = !out_valid_r || !out_stall;
    sts.row_last = row_last;
    sts.scroll   = adv_scroll;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A new item never overwrites a result that is still held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.row_load || cmd.scroll_load) |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while stalled");

  // Each glyph starts at its top row.
  a_row_count_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_base |=> (row_cnt_r == '0))
    else $error("row counter not cleared at glyph start");

  // A scroll command is always the final result of its item.
  a_scroll_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.kind == tcgr_pkg::KIND_SCROLL) |->
      (out_item_r.last && out_item_r.pixel_offset == '0))
    else $error("malformed scroll command");

endmodule

// File: rtl/core/text_console_glyph_renderer_top.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_top: 8-pixel-wide text console glyph renderer
//
// Input items carry either a character byte (opcode 0) or one font store
// byte (opcode 1). A printable character yields one glyph-row write per
// glyph row, each with its framebuffer pixel offset, eight pixel bits and
// both colours; line advance past the bottom adds a scroll command.
// Both item channels use valid/stall; the config port is valid/ready and
// takes writes only while no item is in flight.
// Font writes, carriage return, and newline or tab without scroll finish
// in the idle state that accepts them. A character passes the accept
// state, a state for the row-times-pitch multiply, then one glyph row per
// cycle read from the font RAM while the receiver does not stall; a scroll
// adds a scroll state. When the receiver stalls, the result register holds
// and row emission pauses; the input stays stalled until the item's last
// result is loaded. Reset clears the cursor to the top left and loads
// register defaults (80 columns, 30 rows, pitch 640, white on black). The
// font store is not cleared and must be loaded before characters are
// printed.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_top #(
  parameter int GLYPH_HEIGHT = tcgr_pkg::GLYPH_HEIGHT_DEF,
  parameter int GLYPH_COUNT  = tcgr_pkg::GLYPH_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tcgr_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tcgr_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0] cfg_data
);

  tcgr_pkg::ctrl_cmd_t cmd;
  tcgr_pkg::ctrl_sts_t sts;
  logic                cfg_we;

  // A register write completes on the valid/ready handshake.
  assign cfg_we = cfg_valid && cfg_ready;

  tcgr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcgr_dpath #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .GLYPH_COUNT  (GLYPH_COUNT)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
